// ===== hw/rtl/fslm_pkg.sv =====
package fslm_pkg;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 3;
    localparam int SEQ_W    = 32;
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 20;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
    localparam logic [OP_W-1:0] OP_CANCEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_PUBLISH = 3'd2;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
    localparam logic [OP_W-1:0] OP_DROP    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot;
        logic              stream;
        logic [TIME_W-1:0] timestamp;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   out_slot;
        logic                frame_stream;
        logic [SEQ_W-1:0]    frame_sequence;
        logic [TIME_W-1:0]   frame_time;
        logic [LEN_W-1:0]    frame_bytes;
    } t_result;

endpackage

// ===== hw/rtl/fslm_if.sv =====
interface fslm_item_if;
    import fslm_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fslm_result_if;
    import fslm_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fslm_cfg_if;
    import fslm_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fslm_core.sv =====
module fslm_core #(
    parameter int FRAME_SLOTS = 3,
    parameter int READER_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  fslm_pkg::t_item            i_item,
    input  logic [fslm_pkg::LEN_W-1:0] i_frame_length,
    output fslm_pkg::t_result          o_result
);
    import fslm_pkg::*;

    logic [SEQ_W-1:0]       r_slot_seq  [FRAME_SLOTS];
    logic [SEQ_W-1:0]       n_slot_seq  [FRAME_SLOTS];
    logic [TIME_W-1:0]      r_slot_time [FRAME_SLOTS];
    logic [TIME_W-1:0]      n_slot_time [FRAME_SLOTS];
    logic [LEN_W-1:0]       r_slot_len  [FRAME_SLOTS];
    logic [LEN_W-1:0]       n_slot_len  [FRAME_SLOTS];
    logic [READER_BITS-1:0] r_readers   [FRAME_SLOTS];
    logic [READER_BITS-1:0] n_readers   [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] r_slot_kind, n_slot_kind;
    logic [FRAME_SLOTS-1:0] r_slot_valid, n_slot_valid;
    logic [FRAME_SLOTS-1:0] r_writing, n_writing;
    logic                   r_pub_valid, n_pub_valid;
    logic [SLOT_W-1:0]      r_pub_index, n_pub_index;
    logic [SEQ_W-1:0]       r_stream_seq [2];
    logic [SEQ_W-1:0]       n_stream_seq [2];

    logic [FRAME_SLOTS-1:0] is_pub, sel, free, res_onehot;
    logic [SLOT_W-1:0]      res_idx;
    logic                   res_found, slot_ok, acq_ok;
    logic                   pub_flag, pub_writing, pub_kind;
    logic [READER_BITS-1:0] pub_readers;
    logic [SEQ_W-1:0]       pub_seq, seq_next;
    logic [TIME_W-1:0]      pub_time;
    logic [LEN_W-1:0]       pub_len;

    // per-slot decode and one-hot read of the published slot
    always_comb begin
        pub_flag    = 1'b0;
        pub_writing = 1'b0;
        pub_kind    = 1'b0;
        pub_readers = '0;
        pub_seq     = '0;
        pub_time    = '0;
        pub_len     = '0;
        res_onehot  = '0;
        res_idx     = '0;
        for (int i = 0; i < FRAME_SLOTS; i++) begin
            is_pub[i] = r_pub_valid && (r_pub_index == SLOT_W'(i));
            sel[i]    = (i_item.slot == SLOT_W'(i));
            free[i]   = !is_pub[i] && (r_readers[i] == '0) && !r_writing[i];
            pub_flag    = pub_flag | (is_pub[i] & r_slot_valid[i]);
            pub_writing = pub_writing | (is_pub[i] & r_writing[i]);
            pub_kind    = pub_kind | (is_pub[i] & r_slot_kind[i]);
            pub_readers = pub_readers | ({READER_BITS{is_pub[i]}} & r_readers[i]);
            pub_seq     = pub_seq | ({SEQ_W{is_pub[i]}} & r_slot_seq[i]);
            pub_time    = pub_time | ({TIME_W{is_pub[i]}} & r_slot_time[i]);
            pub_len     = pub_len | ({LEN_W{is_pub[i]}} & r_slot_len[i]);
        end
        // lowest free slot wins
        for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
            if (free[i]) begin
                res_onehot    = '0;
                res_onehot[i] = 1'b1;
                res_idx       = SLOT_W'(i);
            end
        end
        res_found = |free;
        slot_ok   = ({1'b0, i_item.slot} < (SLOT_W + 1)'(FRAME_SLOTS));
        acq_ok    = r_pub_valid && pub_flag && !pub_writing
                    && (pub_kind == i_item.stream) && (pub_readers != '1);
        seq_next  = r_stream_seq[i_item.stream] + SEQ_W'(1);
    end

    always_comb begin
        n_slot_seq   = r_slot_seq;
        n_slot_time  = r_slot_time;
        n_slot_len   = r_slot_len;
        n_readers    = r_readers;
        n_slot_kind  = r_slot_kind;
        n_slot_valid = r_slot_valid;
        n_writing    = r_writing;
        n_pub_valid  = r_pub_valid;
        n_pub_index  = r_pub_index;
        n_stream_seq = r_stream_seq;
        o_result     = '0;
        case (i_item.op)
            OP_RESERVE: begin
                if (res_found) begin
                    n_writing         = r_writing | res_onehot;
                    o_result.out_slot = res_idx;
                end else begin
                    o_result.status = ST_NONE;
                end
            end
            OP_CANCEL: begin
                if (!slot_ok) begin
                    o_result.status = ST_BAD_SLOT;
                end else begin
                    n_writing = r_writing & ~sel;
                end
            end
            OP_PUBLISH: begin
                if (!slot_ok) begin
                    o_result.status = ST_BAD_SLOT;
                end else begin
                    n_stream_seq[i_item.stream] = seq_next;
                    for (int i = 0; i < FRAME_SLOTS; i++) begin
                        if (sel[i]) begin
                            n_slot_seq[i]  = seq_next;
                            n_slot_time[i] = i_item.timestamp;
                            n_slot_len[i]  = i_frame_length;
                        end
                    end
                    n_slot_kind  = (r_slot_kind & ~sel) | ({FRAME_SLOTS{i_item.stream}} & sel);
                    n_slot_valid = r_slot_valid | sel;
                    n_writing    = r_writing & ~sel;
                    n_pub_valid  = 1'b1;
                    n_pub_index  = i_item.slot;
                end
            end
            OP_ACQUIRE: begin
                if (acq_ok) begin
                    for (int i = 0; i < FRAME_SLOTS; i++) begin
                        if (is_pub[i]) begin
                            n_readers[i] = r_readers[i] + READER_BITS'(1);
                        end
                    end
                    o_result.out_slot       = r_pub_index;
                    o_result.frame_stream   = pub_kind;
                    o_result.frame_sequence = pub_seq;
                    o_result.frame_time     = pub_time;
                    o_result.frame_bytes    = pub_len;
                end else begin
                    o_result.status = ST_NONE;
                end
            end
            OP_RELEASE: begin
                if (!slot_ok) begin
                    o_result.status = ST_BAD_SLOT;
                end else begin
                    for (int i = 0; i < FRAME_SLOTS; i++) begin
                        if (sel[i] && (r_readers[i] != '0)) begin
                            n_readers[i] = r_readers[i] - READER_BITS'(1);
                        end
                    end
                end
            end
            OP_DROP: begin
                n_pub_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_writing    <= '0;
            r_pub_valid  <= 1'b0;
            r_pub_index  <= '0;
            for (int i = 0; i < FRAME_SLOTS; i++) begin
                r_readers[i] <= '0;
            end
            r_stream_seq[0] <= '0;
            r_stream_seq[1] <= '0;
        end else if (i_en) begin
            r_slot_valid <= n_slot_valid;
            r_writing    <= n_writing;
            r_pub_valid  <= n_pub_valid;
            r_pub_index  <= n_pub_index;
            r_readers    <= n_readers;
            r_stream_seq <= n_stream_seq;
        end
    end

    // metadata is only read behind a set valid flag
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slot_seq  <= n_slot_seq;
            r_slot_time <= n_slot_time;
            r_slot_len  <= n_slot_len;
            r_slot_kind <= n_slot_kind;
        end
    end

endmodule

// ===== hw/rtl/frame_slot_lease_manager.sv =====
// Frame slot lease manager: one writer and many readers share FRAME_SLOTS
// frame buffers. Each transfer on i_item carries one operation and yields
// exactly one transfer on o_result. One operation is taken every cycle while
// o_result keeps up. An operation waits in the input register while the slot
// flag table is decoded, then moves into the result register as the table is
// updated. With o_result always ready, an operation passes the input register
// and then the result register, and its result is offered and transferred. A
// stalled result holds the input register, so at most two operations are
// inside. Each operation sees the slot table as every earlier operation left
// it. frame_length on i_cfg is stored with each publish; write it only when
// no operation is in flight.
module frame_slot_lease_manager #(
    parameter int FRAME_SLOTS = 3,
    parameter int READER_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fslm_item_if.sink     i_item,
    fslm_result_if.source o_result,
    fslm_cfg_if.sink      i_cfg
);
    import fslm_pkg::*;

    logic [LEN_W-1:0] r_frame_length;
    logic             r_in_valid;
    t_item            r_in;
    logic             r_out_valid;
    t_result          r_out;
    t_result          w_result;
    logic             w_advance;

    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready   = !r_in_valid || w_advance;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    fslm_core #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .READER_BITS (READER_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_advance),
        .i_item         (r_in),
        .i_frame_length (r_frame_length),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frame_length <= i_cfg.data;
            end
            if (i_item.valid && i_item.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

endmodule

// ===== hw/rtl/fslm_checker.sv =====
module fslm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_item_valid,
    input logic              i_item_ready,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input fslm_pkg::t_result i_res_data
);
    import fslm_pkg::*;

    logic [1:0] r_pending;
    logic       w_in_xfer, w_out_xfer;

    assign w_in_xfer  = i_item_valid && i_item_ready;
    assign w_out_xfer = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(w_in_xfer) - 2'(w_out_xfer);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_res_valid || r_pending != 2'd0) && r_pending != 2'd3)
        else $error("result without matching item or too many in flight");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_res_ready) ##1 i_res_ready |=> i_res_valid)
        else $error("result late with free output");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_data.status != ST_DONE) |->
        i_res_data.out_slot == '0 && i_res_data.frame_sequence == '0
        && i_res_data.frame_time == '0 && i_res_data.frame_bytes == '0
        && !i_res_data.frame_stream)
        else $error("failed operation carries frame data");

endmodule

bind frame_slot_lease_manager fslm_checker u_fslm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item.valid),
    .i_item_ready (i_item.ready),
    .i_res_valid  (o_result.valid),
    .i_res_ready  (o_result.ready),
    .i_res_data   (o_result.data)
);
